// ----- rtl/wmtf_pkg.sv -----
// shared types, constants and codes for the weighted move-to-front cost block
package wmtf_pkg;

  localparam int unsigned MAX_ITEMS_DEF   = 1024;
  localparam int unsigned WEIGHT_BITS_DEF = 16;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ITEM_W   = 10;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned LIFT_W   = 26;
  localparam int unsigned TOTAL_W  = 48;

  localparam logic [LIFT_W-1:0]  LIFT_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE   = 2'd0,
    KIND_ACCESS  = 2'd1,
    KIND_RESTART = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ITEM_W-1:0]   item;
    logic [WEIGHT_W-1:0] weight_value;
  } req_t;

  typedef struct packed {
    logic [LIFT_W-1:0]  lifted_weight;
    logic [TOTAL_W-1:0] total_cost;
    logic               first_access;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic wr_weight;
    logic restart;
    logic step;
    logic hit_end;
    logic fresh_end;
    logic report;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_write;
    logic is_access;
    logic is_restart;
    logic at_depth;
    logic hit;
  } ctrl_sts_t;

endpackage

// ----- rtl/wmtf_ctrl.sv -----
// controller state machine: decodes requests and sequences the stack walk
module wmtf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  wmtf_pkg::ctrl_sts_t sts_i,
  output wmtf_pkg::ctrl_cmd_t cmd_o,
  output logic                busy
);

  wmtf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wmtf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      wmtf_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.wr_weight = sts_i.is_write;
          cmd_o.restart   = sts_i.is_restart;
          if (sts_i.is_access) begin
            cmd_o.load = 1'b1;
            state_d    = wmtf_pkg::ST_WALK;
          end
        end
      end
      wmtf_pkg::ST_WALK: begin
        if (sts_i.at_depth) begin
          cmd_o.fresh_end = 1'b1;
          state_d         = wmtf_pkg::ST_REPORT;
        end else if (sts_i.hit) begin
          cmd_o.hit_end = 1'b1;
          state_d       = wmtf_pkg::ST_REPORT;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      wmtf_pkg::ST_REPORT: begin
        cmd_o.report = 1'b1;
        state_d      = wmtf_pkg::ST_IDLE;
      end
      default: begin
        state_d = wmtf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/wmtf_datapath.sv -----
// datapath: weight table, recency stack memory, walk registers and totals
module wmtf_datapath #(
  parameter int unsigned MAX_ITEMS   = wmtf_pkg::MAX_ITEMS_DEF,
  parameter int unsigned WEIGHT_BITS = wmtf_pkg::WEIGHT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wmtf_pkg::req_t      req_i,
  input  wmtf_pkg::ctrl_cmd_t cmd_i,
  output wmtf_pkg::ctrl_sts_t sts_o,
  output wmtf_pkg::rsp_t      rsp_o,
  output logic                rsp_valid_o
);

  localparam int unsigned IW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned DW    = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SUM_W = WEIGHT_BITS + IW;
  localparam int unsigned EXT_W =
    ((SUM_W > wmtf_pkg::TOTAL_W) ? SUM_W : wmtf_pkg::TOTAL_W) + 1;

  logic [WEIGHT_BITS-1:0]      wt_mem [MAX_ITEMS];
  logic [wmtf_pkg::ITEM_W-1:0] stk_mem [MAX_ITEMS];

  logic [WEIGHT_BITS-1:0]      wt_q;
  logic [wmtf_pkg::ITEM_W-1:0] stk_q;
  logic [wmtf_pkg::ITEM_W-1:0] item_q, carry_q;
  logic [DW-1:0]               pos_q, depth_q;
  logic [SUM_W-1:0]            sum_q;
  logic [wmtf_pkg::TOTAL_W-1:0] total_q, total_d;
  logic                        add_en_q, fresh_q;
  wmtf_pkg::rsp_t              rsp_q;
  logic                        rsp_valid_q;

  logic                        in_range;
  logic                        stk_we;
  logic [IW-1:0]               stk_raddr;
  logic [EXT_W-1:0]            sum_ext, tot_ext;

  assign in_range = (32'(req_i.item) < 32'(MAX_ITEMS));

  assign sts_o.is_write   = (req_i.kind == wmtf_pkg::KIND_WRITE) && in_range;
  assign sts_o.is_access  = (req_i.kind == wmtf_pkg::KIND_ACCESS) && in_range;
  assign sts_o.is_restart = (req_i.kind == wmtf_pkg::KIND_RESTART);
  assign sts_o.at_depth   = (pos_q == depth_q);
  assign sts_o.hit        = (stk_q == item_q);

  // weight table
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_weight) begin
      wt_mem[IW'(req_i.item)] <= WEIGHT_BITS'(req_i.weight_value);
    end
    wt_q <= wt_mem[IW'(stk_q)];
  end

  // recency stack: each walk step writes the carried entry one place down
  assign stk_we    = cmd_i.step || cmd_i.hit_end ||
                     (cmd_i.fresh_end && (pos_q != DW'(MAX_ITEMS)));
  assign stk_raddr = cmd_i.load ? '0 : IW'(pos_q + DW'(1));

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[pos_q[IW-1:0]] <= carry_q;
    end
    stk_q <= stk_mem[stk_raddr];
  end

  // walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q  <= req_i.item;
      carry_q <= req_i.item;
      pos_q   <= '0;
      sum_q   <= '0;
    end else begin
      if (add_en_q) begin
        sum_q <= sum_q + SUM_W'(wt_q);
      end
      if (cmd_i.step) begin
        carry_q <= stk_q;
        pos_q   <= pos_q + DW'(1);
      end
    end
    if (cmd_i.hit_end) begin
      fresh_q <= 1'b0;
    end else if (cmd_i.fresh_end) begin
      fresh_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_en_q <= 1'b0;
    end else begin
      add_en_q <= cmd_i.step;
    end
  end

  // saturating total
  assign sum_ext = EXT_W'(sum_q);
  assign tot_ext = EXT_W'(total_q) + sum_ext;

  always_comb begin
    if (tot_ext > EXT_W'(wmtf_pkg::TOTAL_MAX)) begin
      total_d = wmtf_pkg::TOTAL_MAX;
    end else begin
      total_d = tot_ext[wmtf_pkg::TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      total_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= cmd_i.report;
      if (cmd_i.restart) begin
        depth_q <= '0;
        total_q <= '0;
      end else begin
        if (cmd_i.fresh_end && (depth_q != DW'(MAX_ITEMS))) begin
          depth_q <= depth_q + DW'(1);
        end
        if (cmd_i.report) begin
          total_q <= total_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.report) begin
      rsp_q.total_cost   <= total_d;
      rsp_q.first_access <= fresh_q;
      if (sum_ext > EXT_W'(wmtf_pkg::LIFT_MAX)) begin
        rsp_q.lifted_weight <= wmtf_pkg::LIFT_MAX;
      end else begin
        rsp_q.lifted_weight <= wmtf_pkg::LIFT_W'(sum_q);
      end
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

// ----- rtl/weighted_move_to_front_cost_top.sv -----
// top level of the weighted move-to-front cost block
// A request is taken at a clock edge where start is high and busy is low.
// Weight writes, restarts and ignored requests (unused kind, item out of
// range) give no result. An access walks the recency stack from the top,
// one entry per cycle through the stack memory, and holds busy until the
// walk reaches the item's position in the stack (the current stack depth
// for a first access) and the result is reported. The result appears on
// rsp_o with rsp_valid_o high for exactly one cycle, in the first cycle
// busy is low again; the receiver cannot stall it and must take it in that
// cycle. No clearing pass is needed after reset.
module weighted_move_to_front_cost_top #(
  parameter int unsigned MAX_ITEMS   = wmtf_pkg::MAX_ITEMS_DEF,
  parameter int unsigned WEIGHT_BITS = wmtf_pkg::WEIGHT_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  wmtf_pkg::req_t req_i,
  output wmtf_pkg::rsp_t rsp_o,
  output logic           rsp_valid_o
);

  wmtf_pkg::ctrl_cmd_t cmd;
  wmtf_pkg::ctrl_sts_t sts;

  wmtf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  wmtf_datapath #(
    .MAX_ITEMS   (MAX_ITEMS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o)
  );

`ifndef NO_ASSERTIONS
  a_rsp_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !busy)
    else $error("result strobe while busy");

  a_rsp_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o)
    else $error("back to back result strobes");

  a_busy_from_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted request");

  a_one_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.step, cmd.hit_end, cmd.fresh_end, cmd.report, cmd.load}))
    else $error("conflicting walk commands");
`endif

endmodule
